@@ sv/rsi_pkg.sv @@
// Shared types, constants and saturating helpers for the ray/sphere intersector.
package rsi_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int IW         = 64;

	localparam int MUL_LAT  = 3;
	localparam int SQRT_LAT = (IW + FRAC_BITS) / 2;
	localparam int DIV_LAT  = IW + FRAC_BITS + 1;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [IW-1:0] q_t;
	typedef logic signed [DATA_WIDTH-1:0] w_t;
	typedef logic [DATA_WIDTH-2:0] rad_t;

	localparam q_t SMAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW:0] SMAX_X = {2'b00, {(IW-1){1'b1}}};
	localparam logic signed [IW:0] SMIN_X = -SMAX_X;
	localparam q_t WMAX = {{(IW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam q_t WMIN = ~WMAX;

	localparam rad_t RADIUS_RST = rad_t'(1) << FRAC_BITS;
	localparam w_t   NEAR_RST   = w_t'(66);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_RADIUS   = 3'd3,
		CFG_NEAR     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		w_t origin_x;
		w_t origin_y;
		w_t origin_z;
		w_t dir_x;
		w_t dir_y;
		w_t dir_z;
		w_t far_limit;
	} ray_t;

	typedef struct packed {
		logic hit;
		w_t   hit_t;
		w_t   point_x;
		w_t   point_y;
		w_t   point_z;
		w_t   normal_x;
		w_t   normal_y;
		w_t   normal_z;
		logic front_face;
	} res_t;

	function automatic q_t sxw(input w_t v);
		return q_t'(v);
	endfunction

	function automatic q_t sadd(input q_t x, input q_t y);
		logic signed [IW:0] s;
		s = $signed({x[IW-1], x}) + $signed({y[IW-1], y});
		if (s > SMAX_X) return SMAX;
		if (s < SMIN_X) return -SMAX;
		return s[IW-1:0];
	endfunction

	function automatic w_t clampw(input q_t x);
		if (x > WMAX) return WMAX[DATA_WIDTH-1:0];
		if (x < WMIN) return WMIN[DATA_WIDTH-1:0];
		return x[DATA_WIDTH-1:0];
	endfunction

	function automatic w_t org_of(input ray_t r, input logic [1:0] i);
		case (i)
			2'd0:    return r.origin_x;
			2'd1:    return r.origin_y;
			default: return r.origin_z;
		endcase
	endfunction

	function automatic w_t dir_of(input ray_t r, input logic [1:0] i);
		case (i)
			2'd0:    return r.dir_x;
			2'd1:    return r.dir_y;
			default: return r.dir_z;
		endcase
	endfunction

endpackage

@@ sv/rsi_delay.sv @@
// Enable-gated delay line that carries side data alongside an arithmetic unit.
module rsi_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) pipe_q[k] <= '0;
		end else if (en) begin
			pipe_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) pipe_q[k] <= pipe_q[k-1];
		end
	end

	assign q = pipe_q[DEPTH-1];
endmodule

@@ sv/rsi_mul.sv @@
// Three-stage saturating fixed-point multiplier built from 32x32 partial products.
module rsi_mul (
	input  logic        clk,
	input  logic        en,
	input  rsi_pkg::q_t a,
	input  rsi_pkg::q_t b,
	output rsi_pkg::q_t p
);
	import rsi_pkg::*;

	logic [IW-1:0] ma, mb;
	logic [IW-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic          neg_s1, neg_s2;
	logic [2*IW-1:0] prod_s2;
	logic          over;
	q_t            mg;
	q_t            p_s3;

	assign ma = a[IW-1] ? IW'(-a) : IW'(a);
	assign mb = b[IW-1] ? IW'(-b) : IW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[IW-1] ^ b[IW-1];
			ll_s1  <= ma[31:0]  * mb[31:0];
			lh_s1  <= ma[31:0]  * mb[63:32];
			hl_s1  <= ma[63:32] * mb[31:0];
			hh_s1  <= ma[63:32] * mb[63:32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2  <= neg_s1;
			prod_s2 <= {64'b0, ll_s1} + {32'b0, lh_s1, 32'b0}
			         + {32'b0, hl_s1, 32'b0} + {hh_s1, 64'b0};
		end
	end

	// drop the fraction, saturate the magnitude, then restore the sign
	assign over = (|prod_s2[2*IW-1:IW+FRAC_BITS]) | prod_s2[IW-1+FRAC_BITS];
	assign mg   = over ? SMAX : {1'b0, prod_s2[IW-2+FRAC_BITS:FRAC_BITS]};

	always_ff @(posedge clk) begin
		if (en) p_s3 <= neg_s2 ? -mg : mg;
	end

	assign p = p_s3;
endmodule

@@ sv/rsi_sqrt.sv @@
// Pipelined digit-by-digit square root, one root bit per stage.
module rsi_sqrt (
	input  logic        clk,
	input  logic        en,
	input  rsi_pkg::q_t rad_in,
	output rsi_pkg::q_t root_out
);
	import rsi_pkg::*;

	localparam int RW = IW + FRAC_BITS;
	localparam int QB = RW / 2;
	localparam int MW = QB + 3;

	logic [RW-1:0] rad_q  [QB];
	logic [MW-1:0] rem_q  [QB];
	logic [QB-1:0] root_q [QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] rad_c;
		logic [MW-1:0] rem_c, rem_sh, trial;
		logic [QB-1:0] root_c;
		logic          ge;

		if (k == 0) begin : g_first
			assign rad_c  = {rad_in, {FRAC_BITS{1'b0}}};
			assign rem_c  = '0;
			assign root_c = '0;
		end else begin : g_next
			assign rad_c  = rad_q[k-1];
			assign rem_c  = rem_q[k-1];
			assign root_c = root_q[k-1];
		end

		assign rem_sh = {rem_c[MW-3:0], rad_c[RW-1 -: 2]};
		assign trial  = {{(MW-QB-2){1'b0}}, root_c, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k]  <= rad_c << 2;
				rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
				root_q[k] <= {root_c[QB-2:0], ge};
			end
		end
	end

	assign root_out = q_t'({{(IW-QB){1'b0}}, root_q[QB-1]});
endmodule

@@ sv/rsi_div.sv @@
// Pipelined restoring fixed-point divider, one quotient bit per stage, saturating.
module rsi_div (
	input  logic          clk,
	input  logic          en,
	input  rsi_pkg::q_t   num,
	input  logic [63:0]   den,
	output rsi_pkg::q_t   quo
);
	import rsi_pkg::*;

	localparam int N = IW + FRAC_BITS;

	logic [N-1:0]  num_q [N];
	logic [IW-1:0] rem_q [N];
	logic [N-1:0]  quo_q [N];
	logic [IW-1:0] den_q [N];
	logic          neg_q [N];
	logic [IW-1:0] mag;
	logic          over;
	q_t            qm;
	q_t            quo_o;

	assign mag = num[IW-1] ? IW'(-num) : IW'(num);

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [N-1:0]  num_c, quo_c;
		logic [IW-1:0] rem_c, den_c;
		logic          neg_c, ge;
		logic [IW:0]   rem_sh;

		if (k == 0) begin : g_first
			assign num_c = {mag, {FRAC_BITS{1'b0}}};
			assign rem_c = '0;
			assign quo_c = '0;
			assign den_c = den;
			assign neg_c = num[IW-1];
		end else begin : g_next
			assign num_c = num_q[k-1];
			assign rem_c = rem_q[k-1];
			assign quo_c = quo_q[k-1];
			assign den_c = den_q[k-1];
			assign neg_c = neg_q[k-1];
		end

		assign rem_sh = {rem_c, num_c[N-1]};
		assign ge     = rem_sh >= {1'b0, den_c};

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= num_c << 1;
				rem_q[k] <= ge ? IW'(rem_sh - {1'b0, den_c}) : rem_sh[IW-1:0];
				quo_q[k] <= {quo_c[N-2:0], ge};
				den_q[k] <= den_c;
				neg_q[k] <= neg_c;
			end
		end
	end

	// any quotient bit at or above the sign position means overflow
	assign over = |quo_q[N-1][N-1:IW-1];
	assign qm   = over ? SMAX : {1'b0, quo_q[N-1][IW-2:0]};

	always_ff @(posedge clk) begin
		if (en) quo_o <= neg_q[N-1] ? -qm : qm;
	end

	assign quo = quo_o;
endmodule

@@ sv/ray_sphere_intersect.sv @@
// Ray/sphere intersector: signed Q16.16, fully pipelined.
//
// The block takes one ray transfer per clock unless stalled and returns
// exactly one result transfer per ray, in order. The sphere center, radius
// and near limit are set through the write port and must only change while
// no ray is in flight. Throughput is one ray per cycle when not stalled; the
// latency is dominated by the two bit-per-stage dividers (roots, then normal)
// and the bit-per-stage square root. The whole pipe moves on a single
// enable: when a finished result is not taken, every stage holds and
// ray_ready drops; an empty output register never blocks. No hit returns
// all zero fields.
module ray_sphere_intersect (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ray_valid,
	output logic                             ray_ready,
	input  rsi_pkg::ray_t                    ray_data,
	output logic                             res_valid,
	input  logic                             res_ready,
	output rsi_pkg::res_t                    res_data,
	input  logic                             cfg_we,
	input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsi_pkg::DATA_WIDTH-1:0]   cfg_data
);
	import rsi_pkg::*;

	localparam int RAY_W = $bits(ray_t);

	// configuration registers
	w_t   center_x_q, center_y_q, center_z_q, near_q;
	rad_t radius_q;
	w_t   ctr [3];
	q_t   rad64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_RST;
			near_q     <= NEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_CENTER_Z: center_z_q <= cfg_data;
				CFG_RADIUS:   radius_q   <= cfg_data[DATA_WIDTH-2:0];
				CFG_NEAR:     near_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ctr[0] = center_x_q;
	assign ctr[1] = center_y_q;
	assign ctr[2] = center_z_q;
	assign rad64  = q_t'({{(IW-DATA_WIDTH+1){1'b0}}, radius_q});

	// global advance: hold everything while a result waits untaken
	logic en;
	logic res_vld_q;
	res_t res_q;

	assign en        = ~res_vld_q | res_ready;
	assign ray_ready = en;
	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	// ---- stage 1: capture ray, form oc = origin - center
	logic vld_s1;
	ray_t ray_s1;
	q_t   oc_s1 [3];
	q_t   dv_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray_data;
			for (int i = 0; i < 3; i++)
				oc_s1[i] <= sxw(org_of(ray_data, 2'(i))) - sxw(ctr[i]);
		end
	end

	// ---- quadratic terms: d.d, oc.d, oc.oc, r*r
	q_t   m_dd [3], m_od [3], m_oo [3], m_rr;
	logic vld_m1;
	ray_t ray_m1;

	for (genvar i = 0; i < 3; i++) begin : g_mul1
		assign dv_s1[i] = sxw(dir_of(ray_s1, 2'(i)));
		rsi_mul u_dd (.clk(clk), .en(en), .a(dv_s1[i]), .b(dv_s1[i]), .p(m_dd[i]));
		rsi_mul u_od (.clk(clk), .en(en), .a(oc_s1[i]), .b(dv_s1[i]), .p(m_od[i]));
		rsi_mul u_oo (.clk(clk), .en(en), .a(oc_s1[i]), .b(oc_s1[i]), .p(m_oo[i]));
	end
	rsi_mul u_rr (.clk(clk), .en(en), .a(rad64), .b(rad64), .p(m_rr));

	rsi_delay #(.WIDTH(RAY_W + 1), .DEPTH(MUL_LAT)) u_dly_m1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s1, ray_s1}), .q({vld_m1, ray_m1})
	);

	// ---- stages 2-4: saturating sums in model order
	logic vld_s2, vld_s3, vld_s4;
	ray_t ray_s2, ray_s3, ray_s4;
	q_t   a01_s2, b01_s2, c01_s2, a2_s2, b2_s2, c2_s2, rr_s2;
	q_t   a_s3, b_s3, c3_s3, rr_s3;
	q_t   a_s4, b_s4, c_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_m1;
			a01_s2 <= sadd(m_dd[0], m_dd[1]);
			b01_s2 <= sadd(m_od[0], m_od[1]);
			c01_s2 <= sadd(m_oo[0], m_oo[1]);
			a2_s2  <= m_dd[2];
			b2_s2  <= m_od[2];
			c2_s2  <= m_oo[2];
			rr_s2  <= m_rr;

			ray_s3 <= ray_s2;
			a_s3   <= sadd(a01_s2, a2_s2);
			b_s3   <= sadd(b01_s2, b2_s2);
			c3_s3  <= sadd(c01_s2, c2_s2);
			rr_s3  <= rr_s2;

			ray_s4 <= ray_s3;
			a_s4   <= a_s3;
			b_s4   <= b_s3;
			c_s4   <= sadd(c3_s3, -rr_s3);
		end
	end

	// ---- discriminant products b*b, a*c
	q_t   m_bb, m_ac, a_m2, b_m2;
	logic vld_m2;
	ray_t ray_m2;

	rsi_mul u_bb (.clk(clk), .en(en), .a(b_s4), .b(b_s4), .p(m_bb));
	rsi_mul u_ac (.clk(clk), .en(en), .a(a_s4), .b(c_s4), .p(m_ac));

	rsi_delay #(.WIDTH(RAY_W + 1 + 2*IW), .DEPTH(MUL_LAT)) u_dly_m2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s4, ray_s4, a_s4, b_s4}), .q({vld_m2, ray_m2, a_m2, b_m2})
	);

	// ---- stage 5: discriminant and hit precondition
	logic vld_s5, ok_s5;
	ray_t ray_s5;
	q_t   a_s5, b_s5, disc_s5, disc_c;

	assign disc_c = sadd(m_bb, -m_ac);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s5  <= ray_m2;
			a_s5    <= a_m2;
			b_s5    <= b_m2;
			disc_s5 <= disc_c;
			ok_s5   <= (disc_c > 0) && (a_m2 != 0);
		end
	end

	// ---- square root of the discriminant
	q_t   sq_root, a_sq, b_sq;
	logic vld_sq, ok_sq;
	ray_t ray_sq;

	rsi_sqrt u_sqrt (.clk(clk), .en(en), .rad_in(disc_s5), .root_out(sq_root));

	rsi_delay #(.WIDTH(RAY_W + 2 + 2*IW), .DEPTH(SQRT_LAT)) u_dly_sq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s5, ok_s5, ray_s5, a_s5, b_s5}), .q({vld_sq, ok_sq, ray_sq, a_sq, b_sq})
	);

	// ---- stage 6: root numerators
	logic vld_s6, ok_s6;
	ray_t ray_s6;
	q_t   a_s6, num1_s6, num2_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s6  <= ray_sq;
			ok_s6   <= ok_sq;
			a_s6    <= a_sq;
			num1_s6 <= sadd(-b_sq, -sq_root);
			num2_s6 <= sadd(-b_sq, sq_root);
		end
	end

	// ---- both roots divided by a in parallel
	q_t   t1, t2;
	logic vld_dv, ok_dv;
	ray_t ray_dv;

	rsi_div u_div_t1 (.clk(clk), .en(en), .num(num1_s6), .den(a_s6), .quo(t1));
	rsi_div u_div_t2 (.clk(clk), .en(en), .num(num2_s6), .den(a_s6), .quo(t2));

	rsi_delay #(.WIDTH(RAY_W + 2), .DEPTH(DIV_LAT)) u_dly_dv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s6, ok_s6, ray_s6}), .q({vld_dv, ok_dv, ray_dv})
	);

	// ---- stage 7: prefer the nearer root inside (near, far)
	logic vld_s7, ok_s7, in1, in2;
	ray_t ray_s7;
	q_t   t_s7, far_c, near_c;

	assign far_c  = sxw(ray_dv.far_limit);
	assign near_c = sxw(near_q);
	assign in1    = (t1 < far_c) && (t1 > near_c);
	assign in2    = (t2 < far_c) && (t2 > near_c);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s7 <= ray_dv;
			ok_s7  <= ok_dv & (in1 | in2);
			t_s7   <= in1 ? t1 : t2;
		end
	end

	// ---- hit point products t*d
	q_t   m_td [3], t_m3;
	logic vld_m3, ok_m3;
	ray_t ray_m3;

	for (genvar i = 0; i < 3; i++) begin : g_mul3
		rsi_mul u_td (
			.clk(clk), .en(en), .a(t_s7), .b(sxw(dir_of(ray_s7, 2'(i)))), .p(m_td[i])
		);
	end

	rsi_delay #(.WIDTH(RAY_W + 2 + IW), .DEPTH(MUL_LAT)) u_dly_m3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s7, ok_s7, ray_s7, t_s7}), .q({vld_m3, ok_m3, ray_m3, t_m3})
	);

	// ---- stage 8: point; stage 9: point - center
	logic vld_s8, ok_s8, vld_s9, ok_s9;
	ray_t ray_s8, ray_s9;
	q_t   t_s8, t_s9;
	w_t   p_s8 [3], p_s9 [3];
	q_t   pc_s9 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s8 <= ray_m3;
			ok_s8  <= ok_m3;
			t_s8   <= t_m3;
			for (int i = 0; i < 3; i++)
				p_s8[i] <= clampw(sadd(sxw(org_of(ray_m3, 2'(i))), m_td[i]));

			ray_s9 <= ray_s8;
			ok_s9  <= ok_s8;
			t_s9   <= t_s8;
			for (int i = 0; i < 3; i++) begin
				p_s9[i]  <= p_s8[i];
				pc_s9[i] <= sxw(p_s8[i]) - sxw(ctr[i]);
			end
		end
	end

	// ---- normal = (p - center) / radius
	q_t   q_n [3], t_dn;
	w_t   p_dn [3];
	logic vld_dn, ok_dn;
	ray_t ray_dn;

	for (genvar i = 0; i < 3; i++) begin : g_divn
		rsi_div u_div_n (.clk(clk), .en(en), .num(pc_s9[i]), .den(rad64), .quo(q_n[i]));
	end

	rsi_delay #(.WIDTH(RAY_W + 2 + IW + 3*DATA_WIDTH), .DEPTH(DIV_LAT)) u_dly_dn (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s9, ok_s9, ray_s9, t_s9, p_s9[0], p_s9[1], p_s9[2]}),
		.q({vld_dn, ok_dn, ray_dn, t_dn, p_dn[0], p_dn[1], p_dn[2]})
	);

	// ---- stage 10: clamp the normal, zero it for a zero radius
	logic vld_s10, ok_s10;
	ray_t ray_s10;
	q_t   t_s10;
	w_t   p_s10 [3], n_s10 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s10 <= ray_dn;
			ok_s10  <= ok_dn;
			t_s10   <= t_dn;
			for (int i = 0; i < 3; i++) begin
				p_s10[i] <= p_dn[i];
				n_s10[i] <= (radius_q != '0) ? clampw(q_n[i]) : '0;
			end
		end
	end

	// ---- facing test products d*n
	q_t   m_dn [3], t_m4;
	w_t   p_m4 [3], n_m4 [3];
	logic vld_m4, ok_m4;

	for (genvar i = 0; i < 3; i++) begin : g_mul4
		rsi_mul u_dn (
			.clk(clk), .en(en), .a(sxw(dir_of(ray_s10, 2'(i)))), .b(sxw(n_s10[i])),
			.p(m_dn[i])
		);
	end

	rsi_delay #(.WIDTH(2 + IW + 6*DATA_WIDTH), .DEPTH(MUL_LAT)) u_dly_m4 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({vld_s10, ok_s10, t_s10, p_s10[0], p_s10[1], p_s10[2],
		    n_s10[0], n_s10[1], n_s10[2]}),
		.q({vld_m4, ok_m4, t_m4, p_m4[0], p_m4[1], p_m4[2],
		    n_m4[0], n_m4[1], n_m4[2]})
	);

	// ---- stage 11: d . n
	logic vld_s11, ok_s11;
	q_t   t_s11, dn_s11;
	w_t   p_s11 [3], n_s11 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s11 <= ok_m4;
			t_s11  <= t_m4;
			dn_s11 <= sadd(sadd(m_dn[0], m_dn[1]), m_dn[2]);
			for (int i = 0; i < 3; i++) begin
				p_s11[i] <= p_m4[i];
				n_s11[i] <= n_m4[i];
			end
		end
	end

	// ---- output register: flip the normal to face the ray, zero a miss
	res_t res_c;
	logic front;

	assign front = dn_s11[IW-1];

	always_comb begin
		res_c = '0;
		if (ok_s11) begin
			res_c.hit        = 1'b1;
			res_c.hit_t      = w_t'(t_s11[DATA_WIDTH-1:0]);
			res_c.point_x    = p_s11[0];
			res_c.point_y    = p_s11[1];
			res_c.point_z    = p_s11[2];
			res_c.normal_x   = front ? n_s11[0] : clampw(-sxw(n_s11[0]));
			res_c.normal_y   = front ? n_s11[1] : clampw(-sxw(n_s11[1]));
			res_c.normal_z   = front ? n_s11[2] : clampw(-sxw(n_s11[2]));
			res_c.front_face = front;
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_q <= res_c;
	end

	// valid bits travel with the data and advance on the same enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
			vld_s11   <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= ray_valid;
			vld_s2    <= vld_m1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_m2;
			vld_s6    <= vld_sq;
			vld_s7    <= vld_dv;
			vld_s8    <= vld_m3;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_dn;
			vld_s11   <= vld_m4;
			res_vld_q <= vld_s11;
		end
	end
endmodule

@@ sv/rsi_checker.sv @@
// Port-level checks for the ray/sphere intersector, bound to the top level.
module rsi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          ray_valid,
	input logic          ray_ready,
	input logic          res_valid,
	input logic          res_ready,
	input rsi_pkg::res_t res_data
);
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		ray_ready == (!res_valid || res_ready))
		else $error("ray_ready does not follow output register occupancy");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.hit |-> res_data.hit_t == 0 && res_data.point_x == 0 &&
		res_data.point_y == 0 && res_data.point_z == 0 && res_data.normal_x == 0 &&
		res_data.normal_y == 0 && res_data.normal_z == 0 && !res_data.front_face)
		else $error("miss transfer carries nonzero fields");

	a_zero_normal_back: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.hit && res_data.normal_x == 0 && res_data.normal_y == 0 &&
		res_data.normal_z == 0 |-> !res_data.front_face)
		else $error("front_face set with a zero normal");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");
endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
